// ----- rtl/core/pslt_pkg.sv -----
// Shared types, codes and constants of the packet sequence loss tracker.
`default_nettype none
package pslt_pkg;
   localparam int LOSS_CAP_DEFAULT = 32;
   localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

   localparam logic [1:0] OP_SENT  = 2'd0;
   localparam logic [1:0] OP_RECV  = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;

   localparam logic [3:0] KIND_LOST_REC   = 4'd0;
   localparam logic [3:0] KIND_IN_ORDER   = 4'd1;
   localparam logic [3:0] KIND_DUPLICATE  = 4'd2;
   localparam logic [3:0] KIND_LOSS       = 4'd3;
   localparam logic [3:0] KIND_OUT_ORDER  = 4'd4;
   localparam logic [3:0] KIND_UNEXPECTED = 4'd5;
   localparam logic [3:0] KIND_SENT_NEW   = 4'd6;
   localparam logic [3:0] KIND_RESENT     = 4'd7;
   localparam logic [3:0] KIND_DUE        = 4'd8;
   localparam logic [3:0] KIND_NOT_DUE    = 4'd9;

   localparam int DIV_STEPS = 48;

   typedef struct packed {
      logic [1:0]  operation;
      logic [30:0] seq_no;
      logic [7:0]  frag_no;
      logic [7:0]  frag_cnt;
      logic [47:0] now_us;
   } req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [30:0] lost_seq;
      logic [47:0] lost_time_us;
      logic [30:0] lost_count;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic load_in;
      logic classify;
      logic div_step;
      logic emit_rec;
      logic emit_verdict;
   } cmd_type;

   typedef struct packed {
      logic op_none;
      logic is_loss;
      logic need_div;
      logic div_done;
      logic last_rec;
      logic out_free;
   } sts_type;
endpackage
`default_nettype wire

// ----- rtl/core/pslt_ctrl.sv -----
// Controller state machine of the packet sequence loss tracker.
`default_nettype none
module pslt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pslt_pkg::sts_type sts,
   output pslt_pkg::cmd_type      cmd
);
   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_CLASSIFY = 5'b00010,
      ST_DIVIDE   = 5'b00100,
      ST_RECORD   = 5'b01000,
      ST_VERDICT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            if (sts.op_none) state_in = ST_IDLE;
            else if (sts.is_loss && sts.need_div) state_in = ST_DIVIDE;
            else if (sts.is_loss) state_in = ST_RECORD;
            else state_in = ST_VERDICT;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_RECORD;
         end
         ST_RECORD: begin
            if (sts.out_free) begin
               cmd.emit_rec = 1'b1;
               if (sts.last_rec) state_in = ST_VERDICT;
            end
         end
         ST_VERDICT: begin
            if (sts.out_free) begin
               cmd.emit_verdict = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ----- rtl/core/pslt_dp.sv -----
// Datapath of the packet sequence loss tracker: state, classifier, divider, output register.
`default_nettype none
module pslt_dp #(
   parameter int LOSS_CAP = pslt_pkg::LOSS_CAP_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pslt_pkg::req_type req_item,
   input  wire logic              csr_valid,
   input  wire logic [31:0]       csr_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pslt_pkg::rsp_type      rsp_item,
   input  wire pslt_pkg::cmd_type cmd,
   output pslt_pkg::sts_type      sts
);
   localparam int CW = $clog2(LOSS_CAP + 1);
   localparam int DCW = $clog2(pslt_pkg::DIV_STEPS);

   pslt_pkg::req_type in_ff;
   logic [31:0] timeout_ff;
   logic        rx_valid_ff, tx_valid_ff;
   logic [30:0] rx_seq_ff, tx_seq_ff;
   logic [7:0]  rx_frag_ff, rx_cnt_ff;
   logic [47:0] rx_time_ff, tx_time_ff;
   logic [3:0]  kind_ff;
   logic [30:0] cnt_ff, idx_ff;
   logic [CW-1:0] left_ff;
   logic [47:0] cur_ff, delta_ff, quo_ff;
   logic [33:0] rem_ff, dvs_ff;
   logic [DCW-1:0] dcnt_ff;
   logic        rsp_valid_ff;
   pslt_pkg::rsp_type rsp_ff;

   logic signed [33:0] seq_gap, frag_gap, prev_count, prev_frag, gap, missing;
   logic        in_order, dup, loss, due;
   logic [3:0]  kind_c;
   logic [30:0] cnt_c;
   logic [CW-1:0] emit_c;
   logic [47:0] num_c, age;
   logic [7:0]  total_n;
   logic [34:0] shift;
   logic        ge;
   logic [34:0] diff;
   logic        out_free;

   always_comb begin
      total_n = (in_ff.frag_cnt == 8'd0) ? 8'd1 : in_ff.frag_cnt;
      if (rx_valid_ff) begin
         seq_gap = $signed({3'd0, in_ff.seq_no}) - $signed({3'd0, rx_seq_ff});
         prev_count = $signed({26'd0, rx_cnt_ff});
         prev_frag = $signed({26'd0, rx_frag_ff});
         frag_gap = (seq_gap == 34'sd0) ?
            $signed({26'd0, in_ff.frag_no}) - $signed({26'd0, rx_frag_ff}) :
            $signed({26'd0, in_ff.frag_no});
      end else begin
         seq_gap = 34'sd1;
         prev_count = 34'sd1;
         prev_frag = 34'sd0;
         frag_gap = 34'sd0;
      end
      in_order = (seq_gap == 34'sd1 && prev_count - 34'sd1 == prev_frag && frag_gap == 34'sd0)
         || (seq_gap == 34'sd0 && frag_gap == 34'sd1);
      dup = (seq_gap == 34'sd0 && frag_gap == 34'sd0);
      gap = prev_count - 34'sd1 - prev_frag + frag_gap + seq_gap;
      missing = gap - 34'sd1;
      loss = !in_order && !dup && (gap > 34'sd1);
      cnt_c = (missing > 34'sd2147483647) ? 31'h7FFFFFFF : missing[30:0];
      emit_c = (missing > 34'(LOSS_CAP)) ? CW'(LOSS_CAP) : missing[CW-1:0];
      num_c = (in_ff.now_us >= rx_time_ff) ? in_ff.now_us - rx_time_ff : 48'd0;
      age = in_ff.now_us - tx_time_ff;
      due = tx_valid_ff && (!rx_valid_ff || rx_seq_ff < tx_seq_ff) &&
         in_ff.now_us >= tx_time_ff && age > {16'd0, timeout_ff};
      kind_c = pslt_pkg::KIND_UNEXPECTED;
      case (in_ff.operation)
         pslt_pkg::OP_SENT:
            kind_c = (!tx_valid_ff || tx_seq_ff < in_ff.seq_no) ?
               pslt_pkg::KIND_SENT_NEW : pslt_pkg::KIND_RESENT;
         pslt_pkg::OP_RECV: begin
            if (in_order) kind_c = pslt_pkg::KIND_IN_ORDER;
            else if (dup) kind_c = pslt_pkg::KIND_DUPLICATE;
            else if (loss) kind_c = pslt_pkg::KIND_LOSS;
            else if (seq_gap < 34'sd1) kind_c = pslt_pkg::KIND_OUT_ORDER;
            else kind_c = pslt_pkg::KIND_UNEXPECTED;
         end
         pslt_pkg::OP_CHECK:
            kind_c = due ? pslt_pkg::KIND_DUE : pslt_pkg::KIND_NOT_DUE;
         default: kind_c = pslt_pkg::KIND_UNEXPECTED;
      endcase
      shift = {rem_ff, quo_ff[47]};
      diff = shift - {1'b0, dvs_ff};
      ge = (shift >= {1'b0, dvs_ff});
      out_free = !rsp_valid_ff || rsp_ready;
      sts.op_none = (in_ff.operation != pslt_pkg::OP_SENT) &&
         (in_ff.operation != pslt_pkg::OP_RECV) && (in_ff.operation != pslt_pkg::OP_CHECK);
      sts.is_loss = (in_ff.operation == pslt_pkg::OP_RECV) && loss;
      sts.need_div = gap > 34'sd2;
      sts.div_done = (dcnt_ff == DCW'(pslt_pkg::DIV_STEPS - 1));
      sts.last_rec = (left_ff == CW'(1));
      sts.out_free = out_free;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) in_ff <= req_item;
      if (cmd.classify) begin
         kind_ff <= kind_c;
         cnt_ff <= (kind_c == pslt_pkg::KIND_LOSS) ? cnt_c : 31'd0;
         left_ff <= emit_c;
         cur_ff <= rx_time_ff;
         idx_ff <= rx_seq_ff + 31'd1;
         delta_ff <= num_c;
         quo_ff <= num_c;
         rem_ff <= 34'd0;
         dvs_ff <= gap - 34'sd2;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? diff[33:0] : shift[33:0];
         quo_ff <= {quo_ff[46:0], ge};
         dcnt_ff <= dcnt_ff + DCW'(1);
         if (sts.div_done) delta_ff <= {quo_ff[46:0], ge};
      end
      if (cmd.emit_rec) begin
         rsp_ff <= '{pslt_pkg::KIND_LOST_REC, idx_ff, cur_ff, cnt_ff, 1'b0};
         cur_ff <= cur_ff + delta_ff;
         idx_ff <= idx_ff + 31'd1;
         left_ff <= left_ff - CW'(1);
      end
      if (cmd.emit_verdict) begin
         rsp_ff <= '{kind_ff, 31'd0, 48'd0, cnt_ff, 1'b1};
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         timeout_ff <= pslt_pkg::TIMEOUT_RESET;
         rx_valid_ff <= 1'b0;
         rx_seq_ff <= '0;
         rx_frag_ff <= '0;
         rx_cnt_ff <= 8'd1;
         rx_time_ff <= '0;
         tx_valid_ff <= 1'b0;
         tx_seq_ff <= '0;
         tx_time_ff <= '0;
      end else begin
         if (csr_valid) timeout_ff <= csr_data;
         if (cmd.emit_rec || cmd.emit_verdict) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.emit_verdict) begin
            if (kind_ff == pslt_pkg::KIND_IN_ORDER || kind_ff == pslt_pkg::KIND_LOSS) begin
               rx_valid_ff <= 1'b1;
               rx_seq_ff <= in_ff.seq_no;
               rx_frag_ff <= in_ff.frag_no;
               rx_cnt_ff <= total_n;
               rx_time_ff <= in_ff.now_us;
            end
            if (kind_ff == pslt_pkg::KIND_SENT_NEW) begin
               tx_valid_ff <= 1'b1;
               tx_seq_ff <= in_ff.seq_no;
               tx_time_ff <= in_ff.now_us;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;
endmodule
`default_nettype wire

// ----- rtl/core/packet_sequence_loss_tracker_top.sv -----
// Top level of the packet sequence loss tracker.
// One item at a time. A send, a check, or a receive that is not a loss gives
// one result. A loss first emits m = min(missing, LOSS_CAP) lost records and
// then its verdict; when more than one number is missing, the one-bit-a-cycle
// divider first sets the time step. All results wait on output backpressure.
// An item with an unknown operation gives no result. Otherwise a new item is
// taken once the final result is in the output register. The timeout register may be written at any time.
`default_nettype none
module packet_sequence_loss_tracker_top #(
   parameter int LOSS_CAP = pslt_pkg::LOSS_CAP_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pslt_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pslt_pkg::rsp_type      rsp_item,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [31:0]       csr_data
);
   pslt_pkg::cmd_type cmd;
   pslt_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   pslt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .sts(sts), .cmd(cmd)
   );

   pslt_dp #(.LOSS_CAP(LOSS_CAP)) u_dp (
      .clock(clock), .reset(reset), .req_item(req_item),
      .csr_valid(csr_valid), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .cmd(cmd), .sts(sts)
   );
endmodule
`default_nettype wire

// ----- tb/loss_tracker_checker.sv -----
// Checker for the packet sequence loss tracker: predicts every result and compares it.
`default_nettype none
module loss_tracker_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire pslt_pkg::req_type req_item,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire pslt_pkg::rsp_type rsp_item,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [31:0]       csr_data,
   output int                     fail_count,
   output int                     pending,
   output int                     result_count,
   output int                     record_count
);
   timeunit 1ns;
   timeprecision 1ps;

   pslt_pkg::rsp_type expected_rsp[$];
   logic [31:0] timeout_us;
   logic        have_rx, have_tx;
   logic [30:0] rx_seq, tx_seq;
   logic [7:0]  rx_frag, rx_total;
   logic [47:0] rx_time, tx_time;

   function automatic pslt_pkg::rsp_type make_rsp(logic [3:0] kind, logic [30:0] seq,
                                        logic [47:0] t, logic [30:0] cnt, logic last);
      pslt_pkg::rsp_type r;
      r.kind = kind;
      r.lost_seq = seq;
      r.lost_time_us = t;
      r.lost_count = cnt;
      r.last_of_run = last;
      return r;
   endfunction

   task automatic store_rx(pslt_pkg::req_type it, logic [7:0] total);
      have_rx = 1'b1;
      rx_seq = it.seq_no;
      rx_frag = it.frag_no;
      rx_total = total;
      rx_time = it.now_us;
   endtask

   task automatic classify_receive(pslt_pkg::req_type it);
      logic [7:0]  total;
      longint      seq_gap, frag_gap, prev_count, prev_frag, gap, a, b;
      logic [63:0] missing, emit, delta;
      logic [30:0] cnt;
      logic [47:0] cur;
      total = (it.frag_cnt == 8'd0) ? 8'd1 : it.frag_cnt;
      seq_gap = 1;
      frag_gap = 0;
      prev_count = 1;
      prev_frag = 0;
      if (have_rx) begin
         a = it.seq_no;
         b = rx_seq;
         seq_gap = a - b;
         prev_count = rx_total;
         prev_frag = rx_frag;
         a = it.frag_no;
         b = rx_frag;
         frag_gap = (seq_gap == 0) ? a - b : a;
      end
      if ((seq_gap == 1 && prev_count - 1 == prev_frag && frag_gap == 0) ||
          (seq_gap == 0 && frag_gap == 1)) begin
         store_rx(it, total);
         expected_rsp.push_back(make_rsp(pslt_pkg::KIND_IN_ORDER, '0, '0, '0, 1'b1));
         return;
      end
      if (seq_gap == 0 && frag_gap == 0) begin
         expected_rsp.push_back(make_rsp(pslt_pkg::KIND_DUPLICATE, '0, '0, '0, 1'b1));
         return;
      end
      gap = prev_count - 1 - prev_frag + frag_gap + seq_gap;
      if (gap > 1) begin
         missing = gap - 1;
         cnt = (missing > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : missing[30:0];
         emit = (missing > pslt_pkg::LOSS_CAP_DEFAULT) ?
            64'(pslt_pkg::LOSS_CAP_DEFAULT) : missing;
         delta = (it.now_us >= rx_time) ? 64'(it.now_us - rx_time) : 64'd0;
         if (gap > 2)
            delta = delta / 64'(gap - 2);
         cur = rx_time;
         for (longint i = 1; i <= longint'(emit); i++) begin
            expected_rsp.push_back(make_rsp(pslt_pkg::KIND_LOST_REC, rx_seq + 31'(i),
                                            cur, cnt, 1'b0));
            cur = cur + delta[47:0];
         end
         store_rx(it, total);
         expected_rsp.push_back(make_rsp(pslt_pkg::KIND_LOSS, '0, '0, cnt, 1'b1));
         return;
      end
      if (seq_gap < 1)
         expected_rsp.push_back(make_rsp(pslt_pkg::KIND_OUT_ORDER, '0, '0, '0, 1'b1));
      else
         expected_rsp.push_back(make_rsp(pslt_pkg::KIND_UNEXPECTED, '0, '0, '0, 1'b1));
   endtask

   task automatic predict_item(pslt_pkg::req_type it);
      logic due;
      case (it.operation)
         pslt_pkg::OP_SENT: begin
            if (!have_tx || tx_seq < it.seq_no) begin
               have_tx = 1'b1;
               tx_seq = it.seq_no;
               tx_time = it.now_us;
               expected_rsp.push_back(make_rsp(pslt_pkg::KIND_SENT_NEW, '0, '0, '0, 1'b1));
            end else begin
               expected_rsp.push_back(make_rsp(pslt_pkg::KIND_RESENT, '0, '0, '0, 1'b1));
            end
         end
         pslt_pkg::OP_RECV: classify_receive(it);
         pslt_pkg::OP_CHECK: begin
            due = have_tx && (!have_rx || rx_seq < tx_seq) && it.now_us >= tx_time &&
                  (it.now_us - tx_time) > {16'd0, timeout_us};
            expected_rsp.push_back(make_rsp(due ? pslt_pkg::KIND_DUE : pslt_pkg::KIND_NOT_DUE,
                                            '0, '0, '0, 1'b1));
         end
         default: ;
      endcase
   endtask

   task automatic report(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      pslt_pkg::rsp_type want;
      if (reset) begin
         expected_rsp.delete();
         timeout_us = pslt_pkg::TIMEOUT_RESET;
         have_rx = 1'b0;
         have_tx = 1'b0;
         rx_seq = '0;
         rx_frag = '0;
         rx_total = 8'd1;
         rx_time = '0;
         tx_seq = '0;
         tx_time = '0;
         fail_count = 0;
         result_count <= 0;
         record_count <= 0;
      end else begin
         if (csr_valid && csr_ready)
            timeout_us = csr_data;
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (rsp_item.kind == pslt_pkg::KIND_LOST_REC)
               record_count <= record_count + 1;
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected item, actual %h", $time, rsp_item);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (want.kind !== rsp_item.kind)
                  report("kind", want.kind, rsp_item.kind);
               if (want.lost_seq !== rsp_item.lost_seq)
                  report("lost_seq", want.lost_seq, rsp_item.lost_seq);
               if (want.lost_time_us !== rsp_item.lost_time_us)
                  report("lost_time_us", want.lost_time_us, rsp_item.lost_time_us);
               if (want.lost_count !== rsp_item.lost_count)
                  report("lost_count", want.lost_count, rsp_item.lost_count);
               if (want.last_of_run !== rsp_item.last_of_run)
                  report("last_of_run", want.last_of_run, rsp_item.last_of_run);
            end
         end
         if (req_valid && req_ready)
            predict_item(req_item);
      end
      pending <= expected_rsp.size();
   end
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Top of the loss tracker testbench: clock, reset, stimulus, watchdog and verdict.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   pslt_pkg::req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   pslt_pkg::rsp_type rsp_item;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;
   int          fail_count, pending, result_count, record_count;
   int          idle_pct = 0, stall_pct = 0, items_sent = 0, idle_cycles = 0;
   logic [30:0] stream_seq = 31'd100, sent_seq = 31'd0;
   logic [7:0]  stream_frag = 8'd0, stream_total = 8'd1;
   logic [47:0] clock_us = 48'd5000, sent_us = 48'd0;
   logic [31:0] timeout_now = pslt_pkg::TIMEOUT_RESET;

   packet_sequence_loss_tracker_top uut (
      .clock, .reset, .req_valid, .req_ready, .req_item,
      .rsp_valid, .rsp_ready, .rsp_item, .csr_valid, .csr_ready, .csr_data
   );

   loss_tracker_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_item,
      .rsp_valid, .rsp_ready, .rsp_item, .csr_valid, .csr_ready, .csr_data,
      .fail_count, .pending, .result_count, .record_count
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress", $time);
         $display("testbench failed");
         $finish;
      end
   end

   function automatic pslt_pkg::req_type pack_item(logic [1:0] op, logic [30:0] seq,
                                                   logic [7:0] frag, logic [7:0] total,
                                                   logic [47:0] now);
      pslt_pkg::req_type it;
      it.operation = op;
      it.seq_no = seq;
      it.frag_no = frag;
      it.frag_cnt = total;
      it.now_us = now;
      return it;
   endfunction

   task automatic push(pslt_pkg::req_type it);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(logic [31:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      timeout_now = value;
   endtask

   task automatic push_random();
      int          r;
      logic [30:0] seq;
      logic [7:0]  frag, total;
      r = $urandom_range(99);
      clock_us = clock_us + 48'($urandom_range(1, 3000));
      if (r < 40) begin
         if (stream_frag + 1 < stream_total) begin
            stream_frag++;
         end else begin
            stream_seq++;
            stream_frag = 8'd0;
            stream_total = 8'($urandom_range(0, 4));
            if (stream_total == 8'd0)
               stream_total = 8'd1;
         end
         push(pack_item(pslt_pkg::OP_RECV, stream_seq, stream_frag, stream_total, clock_us));
      end else if (r < 55) begin
         stream_seq = stream_seq + 31'($urandom_range(1, 5));
         stream_frag = 8'($urandom_range(0, 2));
         stream_total = 8'($urandom_range(1, 4));
         push(pack_item(pslt_pkg::OP_RECV, stream_seq, stream_frag, stream_total, clock_us));
      end else if (r < 62) begin
         push(pack_item(pslt_pkg::OP_RECV, stream_seq, stream_frag, stream_total, clock_us));
      end else if (r < 68) begin
         push(pack_item(pslt_pkg::OP_RECV, stream_seq - 31'($urandom_range(0, 4)),
                        8'($urandom_range(0, 3)), 8'($urandom_range(0, 4)), clock_us));
      end else if (r < 78) begin
         seq = ($urandom_range(3) == 0) ? sent_seq : stream_seq + 31'($urandom_range(1, 50));
         if (seq > sent_seq) begin
            sent_seq = seq;
            sent_us = clock_us;
         end
         push(pack_item(pslt_pkg::OP_SENT, seq, 8'($urandom), 8'($urandom), clock_us));
      end else if (r < 90) begin
         push(pack_item(pslt_pkg::OP_CHECK, 31'($urandom), 8'($urandom), 8'($urandom),
                        sent_us + {16'd0, timeout_now} + 48'($urandom_range(0, 2)) - 48'd1));
      end else begin
         seq = 31'($urandom);
         frag = 8'($urandom);
         total = 8'($urandom);
         push(pack_item(2'($urandom), seq, frag, total, {16'($urandom), 32'($urandom)}));
         if ($urandom_range(1) == 0)
            stream_seq = seq;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push(pack_item(pslt_pkg::OP_CHECK, 31'd0, 8'd0, 8'd0, 48'd0));
      push(pack_item(pslt_pkg::OP_SENT, 31'd1000, 8'd0, 8'd0, 48'd1000));
      push(pack_item(pslt_pkg::OP_SENT, 31'd1000, 8'd0, 8'd0, 48'd2000));
      push(pack_item(pslt_pkg::OP_SENT, 31'd7, 8'd0, 8'd0, 48'd2000));
      push(pack_item(pslt_pkg::OP_CHECK, 31'd0, 8'd0, 8'd0, 48'd1001000));
      push(pack_item(pslt_pkg::OP_CHECK, 31'd0, 8'd0, 8'd0, 48'd1001001));
      push(pack_item(pslt_pkg::OP_CHECK, 31'd0, 8'd0, 8'd0, 48'd500));
      push(pack_item(2'd3, 31'h7FFF_FFFF, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF));
      push(pack_item(pslt_pkg::OP_RECV, 31'd100, 8'd0, 8'd0, 48'd3000));
      push(pack_item(pslt_pkg::OP_RECV, 31'd100, 8'd0, 8'd0, 48'd3100));
      push(pack_item(pslt_pkg::OP_RECV, 31'd100, 8'd1, 8'd3, 48'd3200));
      push(pack_item(pslt_pkg::OP_RECV, 31'd101, 8'd0, 8'd1, 48'd3300));
      push(pack_item(pslt_pkg::OP_RECV, 31'd104, 8'd5, 8'd255, 48'd9000));
      push(pack_item(pslt_pkg::OP_RECV, 31'd105, 8'd0, 8'd1, 48'd100));
      push(pack_item(pslt_pkg::OP_RECV, 31'd50, 8'd0, 8'd1, 48'd200));
      push(pack_item(pslt_pkg::OP_RECV, 31'd300, 8'd9, 8'd2, 48'd400));
      push(pack_item(pslt_pkg::OP_RECV, 31'd301, 8'd0, 8'd2, 48'd500));
      push(pack_item(pslt_pkg::OP_RECV, 31'h7FFF_FFFF, 8'd0, 8'd0, 48'hFFFF_FFFF_FF00));
      push(pack_item(pslt_pkg::OP_RECV, 31'h7FFF_FFFF, 8'd40, 8'd0, 48'hFFFF_FFFF_FFFF));
      push(pack_item(pslt_pkg::OP_RECV, 31'd0, 8'd0, 8'd0, 48'd0));
      push(pack_item(pslt_pkg::OP_RECV, 31'd5, 8'd0, 8'd255, 48'd10));
      push(pack_item(pslt_pkg::OP_RECV, 31'h7FFF_FFFF, 8'd255, 8'd1, 48'd20));
      stream_seq = 31'h7FFF_FFFF;
      stream_frag = 8'd255;
      stream_total = 8'd1;

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  write_timeout(32'd0); end
            1: begin idle_pct = 81; stall_pct = 0;  write_timeout(32'hFFFF_FFFF); end
            2: begin idle_pct = 0;  stall_pct = 81; write_timeout($urandom); end
            default: begin idle_pct = 16; stall_pct = 16; write_timeout(32'd50); end
         endcase
         for (int n = 0; n < 37; n++) begin
            push_random();
            if (n == 18)
               drain();
         end
      end

      drain();
      $display("covered %0d items in, %0d results out, %0d lost records",
               items_sent, result_count, record_count);
      $display("four idle and stall phases, timeout from zero to all ones");
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/pslt_pkg.sv
rtl/core/pslt_ctrl.sv
rtl/core/pslt_dp.sv
rtl/core/packet_sequence_loss_tracker_top.sv
tb/loss_tracker_checker.sv
tb/testbench.sv
